### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared constants and byte-level functions for the aes block cipher
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int SCHED_WORDS_DEF = 60;
   localparam int STORE_CAP       = 60;
   localparam int CSR_ADDR_W      = 6;

   localparam logic [2:0] REG_KEY_SIZE = 3'd0;
   localparam logic [2:0] REG_DECRYPT  = 3'd1;
   localparam logic [2:0] REG_KEY_0    = 3'd2;
   localparam logic [2:0] REG_KEY_1    = 3'd3;
   localparam logic [2:0] REG_KEY_2    = 3'd4;
   localparam logic [2:0] REG_KEY_3    = 3'd5;

   localparam logic [1:0] KS_128 = 2'd0;
   localparam logic [1:0] KS_192 = 2'd1;

   typedef logic [7:0] byte_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   function automatic byte_type isbox(input byte_type a);
      byte_type r;
      r = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (sbox(8'(i)) == a) begin
            r = 8'(i);
         end
      end
      return r;
   endfunction

   function automatic byte_type xt(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // columns as 32-bit words, row 0 in the top byte
   function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
      byte_type a [4];
      byte_type b2 [4];
      byte_type b4 [4];
      byte_type b8 [4];
      byte_type m  [4];
      byte_type o  [4];
      for (int k = 0; k < 4; k++) begin
         a[k]  = c[31-8*k -: 8];
         b2[k] = xt(a[k]);
         b4[k] = xt(b2[k]);
         b8[k] = xt(b4[k]);
      end
      for (int r = 0; r < 4; r++) begin
         o[r] = 8'h00;
         for (int k = 0; k < 4; k++) begin
            case ((k - r + 4) & 3)
               0: m[k] = inv ? (b8[k] ^ b4[k] ^ b2[k]) : b2[k];
               1: m[k] = inv ? (b8[k] ^ b2[k] ^ a[k]) : (b2[k] ^ a[k]);
               2: m[k] = inv ? (b8[k] ^ b4[k] ^ a[k]) : a[k];
               default: m[k] = inv ? (b8[k] ^ a[k]) : a[k];
            endcase
            o[r] = o[r] ^ m[k];
         end
      end
      return {o[0], o[1], o[2], o[3]};
   endfunction

   function automatic byte_type rcon(input logic [3:0] i);
      byte_type r;
      case (i)
         4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
         4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
         4'd8: r = 8'h1b; default: r = 8'h36;
      endcase
      return r;
   endfunction

endpackage

### rtl/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// aes_block_cipher
// aes ecb engine, 128/192/256-bit keys, one shared round unit
// ----------------------------------------------------------------------------
// usage:
//  - program key_size, decrypt_mode and key parts over the csr apb port
//    (64-bit data, register i at byte address 8*i) while idle
//  - req_ channel: one 128-bit block plus last flag per transfer
//  - rsp_ channel: one result block per request, last flag copied
// sequencing:
//  - a stale key schedule (after reset or a key write) is expanded first,
//    one schedule word per cycle
//  - the round-key store gives one word per cycle, so the initial key add
//    and each of the 10, 12 or 14 rounds wait until all four key words are
//    gathered; rsp_valid rises when the result enters the output register
//  - req_stall is high from the transfer until the result moves into the
//    output register, so no new block is taken before that
// reset: clears control state, the csr registers, the output valid and the schedule valid flag
// stall: a stalled result holds in the output register until taken; the
//   next block is computed meanwhile and waits in the engine if still held
// ----------------------------------------------------------------------------
module aes_block_cipher #(
   parameter int SCHEDULE_WORDS = aes_pkg::SCHED_WORDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [63:0]                    req_block_high,
   input  logic [63:0]                    req_block_low,
   input  logic                           req_block_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [63:0]                    rsp_out_high,
   output logic [63:0]                    rsp_out_low,
   output logic                           rsp_out_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [aes_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready
);
   import aes_pkg::*;

   localparam int WORDS = (SCHEDULE_WORDS < STORE_CAP) ? SCHEDULE_WORDS : STORE_CAP;
   localparam int IDX_W = $clog2(WORDS);

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXP   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   // csr registers
   logic [1:0]  key_size_ff;
   logic        decrypt_ff;
   logic [63:0] key_ff [4];
   logic        sched_ok_ff;
   logic        csr_wr;
   logic [2:0]  csr_reg;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_reg = paddr[5:3];

   always_comb begin
      case (csr_reg)
         REG_KEY_SIZE: prdata = {62'd0, key_size_ff};
         REG_DECRYPT:  prdata = {63'd0, decrypt_ff};
         REG_KEY_0:    prdata = key_ff[0];
         REG_KEY_1:    prdata = key_ff[1];
         REG_KEY_2:    prdata = key_ff[2];
         REG_KEY_3:    prdata = key_ff[3];
         default:      prdata = 64'd0;
      endcase
   end

   // effective key length in words, shrunk to what the store holds
   logic [3:0] nk;
   always_comb begin
      if (key_size_ff == KS_128) begin
         nk = 4'd4;
      end else if (key_size_ff == KS_192) begin
         nk = 4'd6;
      end else begin
         nk = 4'd8;
      end
      if (nk == 4'd8 && WORDS < 60) begin
         nk = 4'd6;
      end
      if (nk == 4'd6 && WORDS < 52) begin
         nk = 4'd4;
      end
   end
   logic [3:0] nr;
   logic [5:0] total;
   assign nr    = nk + 4'd6;
   assign total = 6'd28 + {nk, 2'b00};

   // state
   logic [2:0]   state_ff, state_in;
   logic [5:0]   widx_ff, widx_in;      // expansion word index
   logic [3:0]   kpos_ff, kpos_in;      // widx mod nk
   logic [3:0]   kcnt_ff, kcnt_in;      // widx / nk - 1 (rcon index)
   logic [3:0]   rnd_ff, rnd_in;        // current round number
   logic [1:0]   col_ff, col_in;
   logic [127:0] st_ff, st_in;
   logic         last_ff, last_in;
   logic [127:0] rk_ff, rk_in;          // round key being gathered
   logic         dec_ff, dec_in;

   // output register
   logic [63:0]  out_high_ff, out_low_ff;
   logic         out_last_ff;
   logic         out_vld_ff, out_vld_in;
   logic         out_load;

   // round key store and a window of the last 8 words for expansion
   logic [31:0]  store [WORDS];
   logic [31:0]  win_ff [8];
   logic [31:0]  rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic         st_wr;
   logic [31:0]  new_word;

   // key schedule step
   logic [31:0] prev, tw, seed;
   always_comb begin
      prev = win_ff[0];
      if (kpos_ff == 4'd0) begin
         tw = sub_word({prev[23:0], prev[31:24]}) ^ {rcon(kcnt_ff), 24'd0};
      end else if (nk == 4'd8 && kpos_ff == 4'd4) begin
         tw = sub_word(prev);
      end else begin
         tw = prev;
      end
      // word i-nk sits at window slot nk-1
      new_word = win_ff[3'(nk - 4'd1)] ^ tw;
      seed = key_ff[widx_ff[2:1]][(widx_ff[0] ? 31 : 63) -: 32];
   end

   // round unit: one full round once the fourth key word is in rd_ff
   logic [127:0] full_key;
   logic [31:0]  col_w [4];
   logic [31:0]  rk_w  [4];
   logic [31:0]  imx_w [4];
   logic [31:0]  esr_w [4];
   logic [127:0] enc_full, dec_next_full;
   logic         fin, dec_first;
   always_comb begin
      full_key  = {rk_ff[95:0], rd_ff};
      fin       = (rnd_ff == nr);
      // first inverse round after the initial key add has no inverse mix
      dec_first = (rnd_ff == nr - 4'd1);
      for (int c = 0; c < 4; c++) begin
         col_w[c] = st_ff[127-32*c -: 32];
         rk_w[c]  = full_key[127-32*c -: 32];
         imx_w[c] = dec_first ? col_w[c] : mix_col(col_w[c], 1'b1);
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            esr_w[c][31-8*r -: 8] = sbox(col_w[(c + r) & 3][31-8*r -: 8]);
            dec_next_full[127-32*c-8*r -: 8] =
               isbox(imx_w[(c - r + 4) & 3][31-8*r -: 8]) ^ rk_w[c][31-8*r -: 8];
         end
      end
      // encrypt: sub, shift, [mix], add key
      for (int c = 0; c < 4; c++) begin
         enc_full[127-32*c -: 32] = rk_w[c] ^ (fin ? esr_w[c] : mix_col(esr_w[c], 1'b0));
      end
   end

   // round key word address for the gather
   logic [3:0] rk_rnd;
   always_comb begin
      if (state_ff == ST_EXP || state_ff == ST_IDLE) begin
         rk_rnd = decrypt_ff ? nr : 4'd0;
      end else begin
         rk_rnd = rnd_in;
      end
      rd_addr = IDX_W'({rk_rnd, col_in});
   end

   assign out_load = (state_ff == ST_OUT) && (!out_vld_ff || !rsp_stall);

   always_comb begin
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      widx_in  = widx_ff;
      kpos_in  = kpos_ff;
      kcnt_in  = kcnt_ff;
      rnd_in   = rnd_ff;
      col_in   = col_ff;
      st_in    = st_ff;
      last_in  = last_ff;
      rk_in    = rk_ff;
      dec_in   = dec_ff;
      st_wr    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            col_in = 2'd0;
            if (req_valid) begin
               st_in   = {req_block_high, req_block_low};
               last_in = req_block_last;
               dec_in  = decrypt_ff;
               rnd_in  = decrypt_ff ? nr : 4'd0;
               widx_in = 6'd0;
               kpos_in = 4'd0;
               kcnt_in = 4'd15;
               state_in = sched_ok_ff ? ST_LOAD : ST_EXP;
            end
         end
         ST_EXP: begin
            st_wr   = 1'b1;
            widx_in = widx_ff + 6'd1;
            if (kpos_ff == nk - 4'd1) begin
               kpos_in = 4'd0;
               kcnt_in = kcnt_ff + 4'd1;
            end else begin
               kpos_in = kpos_ff + 4'd1;
            end
            col_in = 2'd0;
            if (widx_ff == total - 6'd1) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD, ST_ROUND: begin
            // gather one key word per cycle, apply when all four are in
            rk_in  = {rk_ff[95:0], rd_ff};
            col_in = col_ff + 2'd1;
            if (col_ff == 2'd3) begin
               // rd_ff holds word 3 of the key for round rnd_ff
               if (state_ff == ST_LOAD) begin
                  st_in = st_ff ^ full_key;
               end else if (dec_ff) begin
                  st_in = dec_next_full;
               end else begin
                  st_in = enc_full;
               end
               if ((dec_ff && rnd_ff == 4'd0) || (!dec_ff && rnd_ff == nr)) begin
                  state_in = ST_OUT;
               end else begin
                  rnd_in   = dec_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_wr) begin
         store[IDX_W'(widx_ff)] <= (widx_ff < {2'b00, nk}) ? seed : new_word;
      end
      rd_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_vld_ff  <= 1'b0;
         sched_ok_ff <= 1'b0;
         key_size_ff <= 2'd0;
         decrypt_ff  <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= 64'd0;
         end
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr) begin
            case (csr_reg)
               REG_KEY_SIZE: begin
                  key_size_ff <= pwdata[1:0];
                  sched_ok_ff <= 1'b0;
               end
               REG_DECRYPT: decrypt_ff <= pwdata[0];
               REG_KEY_0: begin
                  key_ff[0] <= pwdata; sched_ok_ff <= 1'b0;
               end
               REG_KEY_1: begin
                  key_ff[1] <= pwdata; sched_ok_ff <= 1'b0;
               end
               REG_KEY_2: begin
                  key_ff[2] <= pwdata; sched_ok_ff <= 1'b0;
               end
               REG_KEY_3: begin
                  key_ff[3] <= pwdata; sched_ok_ff <= 1'b0;
               end
               default: ;
            endcase
         end else if (state_ff == ST_EXP && state_in == ST_LOAD) begin
            sched_ok_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in;
      kpos_ff <= kpos_in;
      kcnt_ff <= kcnt_in;
      rnd_ff  <= rnd_in;
      col_ff  <= col_in;
      st_ff   <= st_in;
      last_ff <= last_in;
      rk_ff   <= rk_in;
      dec_ff  <= dec_in;
      if (out_load) begin
         out_high_ff <= st_ff[127:64];
         out_low_ff  <= st_ff[63:0];
         out_last_ff <= last_ff;
      end
      if (st_wr) begin
         win_ff[0] <= (widx_ff < {2'b00, nk}) ? seed : new_word;
         for (int i = 1; i < 8; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = out_vld_ff;
   assign rsp_out_high = out_high_ff;
   assign rsp_out_low  = out_low_ff;
   assign rsp_out_last = out_last_ff;

endmodule
